// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Hamming ECC checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("%m: implication failed");

// a implies c at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("%m: next-cycle implication failed");

// expression never true
`define ASSERT_NEVER(label, clk, rst_n, e) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(e)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== design/hec_pkg.sv =====
// ----------------------------------------------------------------------------
// Hamming ECC package
// Widths, configuration struct and the encode / syndrome functions.
// ----------------------------------------------------------------------------
package hec_pkg;

	localparam int WORD_W            = 64;
	localparam int SYN_W             = 7;
	localparam int DBITS_W           = 6;
	localparam int PAR_W             = 3;
	localparam int DATA_BITS_RST     = 4;
	localparam int DATA_BITS_MAX     = 57;
	localparam int MAX_CODE_BITS_DEF = 64;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [SYN_W-1:0]   syn_t;
	typedef logic [DBITS_W-1:0] dbits_t;
	typedef logic [PAR_W-1:0]   par_t;

	typedef struct packed {
		syn_t  code_len;
		word_t code_mask;
		word_t data_mask;
	} cfg_t;

	function automatic par_t parity_count(input syn_t m);
		par_t r;
		r = par_t'(2**PAR_W - 1);
		for (int k = 2**PAR_W - 1; k >= 0; k--) begin
			if ((1 << k) >= int'(m) + k + 1)
				r = par_t'(k);
		end
		return r;
	endfunction

	function automatic int max_data_bits(input int max_code);
		int best;
		best = 1;
		for (int m = 1; m <= DATA_BITS_MAX; m++) begin
			if (m + int'(parity_count(syn_t'(m))) <= max_code)
				best = m;
		end
		return best;
	endfunction

	function automatic word_t low_mask(input syn_t n);
		return ~({WORD_W{1'b1}} << n);
	endfunction

	function automatic cfg_t derive_cfg(input dbits_t raw, input dbits_t mmax);
		cfg_t   c;
		dbits_t m;
		m = raw;
		if (m == '0)
			m = dbits_t'(1);
		if (m > dbits_t'(DATA_BITS_MAX))
			m = dbits_t'(DATA_BITS_MAX);
		if (m > mmax)
			m = mmax;
		c.code_len  = syn_t'(m) + syn_t'(parity_count(syn_t'(m)));
		c.code_mask = low_mask(c.code_len);
		c.data_mask = low_mask(syn_t'(m));
		return c;
	endfunction

	function automatic word_t scatter(input word_t d);
		word_t w;
		int    j;
		w = '0;
		j = 0;
		for (int pos = 1; pos <= WORD_W; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				w[pos-1] = d[j];
				j++;
			end
		end
		return w;
	endfunction

	function automatic syn_t syndrome(input word_t w);
		syn_t s;
		s = '0;
		for (int k = 0; k < SYN_W; k++) begin
			for (int pos = 1; pos <= WORD_W; pos++) begin
				if (((pos >> k) & 1) != 0)
					s[k] = s[k] ^ w[pos-1];
			end
		end
		return s;
	endfunction

endpackage

// ===== design/hec_if.sv =====
// ----------------------------------------------------------------------------
// Hamming ECC channel interfaces
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
interface hec_in_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [hec_pkg::WORD_W-1:0] word_in;
	modport source (output valid, func, word_in, input ready);
	modport sink   (input valid, func, word_in, output ready);
endinterface

interface hec_out_if;
	logic                       valid;
	logic                       ready;
	logic [hec_pkg::WORD_W-1:0] word_out;
	logic [hec_pkg::SYN_W-1:0]  error_position;
	logic                       corrected;
	logic                       bad_syndrome;
	modport source (output valid, word_out, error_position, corrected, bad_syndrome,
		input ready);
	modport sink   (input valid, word_out, error_position, corrected, bad_syndrome,
		output ready);
endinterface

interface hec_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [hec_pkg::DBITS_W-1:0] data_bits;
	modport source (output valid, data_bits, input ready);
	modport sink   (input valid, data_bits, output ready);
endinterface

// ===== design/hamming_encode_correct.sv =====
// Path: input register, then result register, which drives the result word on dout.
// Throughput: one word per cycle unless dout stalls; input register and result
// register form a two-stage pipeline, with combinational parity trees between them.
// Reset: arst_n clears both pipeline valids and loads data_bits = 4.
// ----------------------------------------------------------------------------
// Hamming ECC encoder / corrector top level
// Configurable single-error-correcting Hamming encode and check.
// ----------------------------------------------------------------------------
module hamming_encode_correct #(
	parameter int MAX_CODE_BITS = hec_pkg::MAX_CODE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hec_cfg_if.sink   cfg,
	hec_in_if.sink    din,
	hec_out_if.source dout
);
	import hec_pkg::*;

	cfg_t cfg_cur;

	hec_cfg #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_out(cfg_cur)
	);

	hec_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_cur),
		.din   (din),
		.dout  (dout)
	);

endmodule

// ===== design/hec_cfg.sv =====
// ----------------------------------------------------------------------------
// Hamming ECC configuration register
// Holds the code length and the code and data masks derived from the data width.
// ----------------------------------------------------------------------------
module hec_cfg #(
	parameter int MAX_CODE_BITS = hec_pkg::MAX_CODE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hec_cfg_if.sink       cfg,
	output hec_pkg::cfg_t cfg_out
);
	import hec_pkg::*;

	localparam dbits_t MMAX    = dbits_t'(max_data_bits(MAX_CODE_BITS));
	localparam cfg_t   CFG_RST = derive_cfg(dbits_t'(DATA_BITS_RST), MMAX);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg.valid) begin
			cfg_q <= derive_cfg(cfg.data_bits, MMAX);
		end
	end

endmodule

// ===== design/hec_datapath.sv =====
// ----------------------------------------------------------------------------
// Hamming ECC datapath
// Input register, encode / check-and-correct logic, result register.
// ----------------------------------------------------------------------------
module hec_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  hec_pkg::cfg_t cfg,
	hec_in_if.sink        din,
	hec_out_if.source     dout
);
	import hec_pkg::*;

	logic  valid_s1;
	logic  func_s1;
	word_t word_s1;

	logic  valid_s2;
	word_t word_s2;
	syn_t  errpos_s2;
	logic  fixed_s2;
	logic  bad_s2;

	logic  adv_s1;
	word_t enc_word;
	syn_t  enc_syn;
	word_t chk_word;
	syn_t  chk_syn;
	logic  chk_fix;
	logic  chk_bad;
	word_t res_word;

	assign adv_s1    = !valid_s2 || dout.ready;
	assign din.ready = !valid_s1 || adv_s1;

	always_comb begin
		enc_word = scatter(word_s1 & cfg.data_mask);
		enc_syn  = syndrome(enc_word);
		for (int k = 0; k < SYN_W; k++) begin
			if (enc_syn[k])
				enc_word[(1 << k) - 1] = 1'b1;
		end
		chk_word = word_s1 & cfg.code_mask;
		chk_syn  = syndrome(chk_word);
		chk_fix  = (chk_syn != '0) && (chk_syn <= cfg.code_len);
		chk_bad  = (chk_syn != '0) && !chk_fix;
		if (chk_fix)
			chk_word = chk_word ^ (word_t'(1) << syn_t'(chk_syn - 1'b1));
		res_word = (func_s1 ? chk_word : enc_word) & cfg.code_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (din.ready)
				valid_s1 <= din.valid;
			if (adv_s1)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			func_s1 <= din.func;
			word_s1 <= din.word_in;
		end
		if (valid_s1 && adv_s1) begin
			word_s2   <= res_word;
			errpos_s2 <= func_s1 ? chk_syn : '0;
			fixed_s2  <= func_s1 && chk_fix;
			bad_s2    <= func_s1 && chk_bad;
		end
	end

	assign dout.valid          = valid_s2;
	assign dout.word_out       = word_s2;
	assign dout.error_position = errpos_s2;
	assign dout.corrected      = fixed_s2;
	assign dout.bad_syndrome   = bad_s2;

endmodule

// ===== design/hec_checker.sv =====
// ----------------------------------------------------------------------------
// Hamming ECC port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hec_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [hec_pkg::WORD_W-1:0] word_out,
	input logic [hec_pkg::SYN_W-1:0]  error_position,
	input logic                       corrected,
	input logic                       bad_syndrome
);
	import hec_pkg::*;

	logic out_stall;

	assign out_stall = out_valid && !out_ready;

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_stall, out_valid && $stable(word_out))
	`ASSERT_NEVER(a_fix_xor_bad, clk, arst_n, out_valid && corrected && bad_syndrome)
	`ASSERT_IMPLY(a_fix_has_pos, clk, arst_n, out_valid && corrected, error_position != '0)
	`ASSERT_IMPLY(a_clean_word, clk, arst_n, out_valid && error_position == '0, !corrected && !bad_syndrome)

endmodule

bind hamming_encode_correct hec_checker u_hec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (dout.valid),
	.out_ready     (dout.ready),
	.word_out      (dout.word_out),
	.error_position(dout.error_position),
	.corrected     (dout.corrected),
	.bad_syndrome  (dout.bad_syndrome)
);

// ===== dv/hamming_encode_correct_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hamming ECC encode / correct testbench
// Drives encode and check words through the valid/ready channels under a
// series of data widths. Each accepted word is predicted with a local model
// of the code: encode, syndrome, single-bit repair, flag for a syndrome past
// the codeword. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module hamming_encode_correct_tb;
	import hec_pkg::*;

	localparam int          MAX_CODE      = MAX_CODE_BITS_DEF;
	localparam int          SEGMENTS      = 15;
	localparam int          WORDS_PER_SEG = 80;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          DRAIN_CYCLES  = 20;
	localparam int          REPORT_MAX    = 50;
	localparam dbits_t      WIDTH_PLAN [10] = '{6'd1, 6'd57, 6'd2, 6'd63, 6'd3,
		6'd58, 6'd0, 6'd4, 6'd11, 6'd26};

	typedef enum logic {OP_ENCODE = 1'b0, OP_CHECK = 1'b1} ecc_op_t;

	typedef struct packed {
		logic  func;
		word_t word;
	} ecc_word_t;

	typedef struct packed {
		word_t code;
		syn_t  pos;
		logic  fixed;
		logic  bad;
	} ecc_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hec_cfg_if cfg_ch ();
	hec_in_if  din_ch ();
	hec_out_if dout_ch ();

	hamming_encode_correct #(
		.MAX_CODE_BITS(MAX_CODE)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	ecc_word_t   send_queue [$];
	ecc_result_t expected_results [$];
	dbits_t      cfg_bits = dbits_t'(DATA_BITS_RST);
	logic        word_taken = 1'b0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned parity_width(input int unsigned m);
		int unsigned r;
		r = 0;
		while ((1 << r) < m + r + 1)
			r++;
		return r;
	endfunction

	function automatic int unsigned code_width(input dbits_t bits);
		int unsigned m;
		m = bits;
		if (m < 1)
			m = 1;
		if (m > DATA_BITS_MAX)
			m = DATA_BITS_MAX;
		while (m > 1 && m + parity_width(m) > MAX_CODE)
			m--;
		return m + parity_width(m);
	endfunction

	function automatic word_t code_mask(input int unsigned n);
		if (n >= WORD_W)
			return '1;
		return (word_t'(1) << n) - word_t'(1);
	endfunction

	function automatic syn_t position_xor(input word_t w, input int unsigned n);
		syn_t s;
		s = '0;
		for (int unsigned pos = 1; pos <= n; pos++)
			if (w[pos-1])
				s = s ^ syn_t'(pos);
		return s;
	endfunction

	function automatic ecc_result_t predict_hamming(input logic func, input word_t word,
		input dbits_t bits);
		ecc_result_t res;
		int unsigned n;
		int unsigned j;
		syn_t        s;
		n = code_width(bits);
		res = '0;
		if (func == OP_ENCODE) begin
			j = 0;
			for (int unsigned pos = 1; pos <= n; pos++) begin
				if ((pos & (pos - 1)) != 0) begin
					res.code[pos-1] = word[j];
					j++;
				end
			end
			s = position_xor(res.code, n);
			for (int k = 0; k < SYN_W; k++)
				if (s[k])
					res.code[(1 << k) - 1] = 1'b1;
		end else begin
			res.code = word & code_mask(n);
			s = position_xor(res.code, n);
			res.pos = s;
			if (s != '0) begin
				if (s <= n) begin
					res.code[s-1] = ~res.code[s-1];
					res.fixed = 1'b1;
				end else begin
					res.bad = 1'b1;
				end
			end
		end
		res.code = res.code & code_mask(n);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input word_t got, input word_t want);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("cycle %0d: %s got %h want %h", cycle_count, field, got, want);
	endtask

	task automatic queue_word(input logic func, input word_t word);
		ecc_word_t item;
		item.func = func;
		item.word = word;
		send_queue.push_back(item);
	endtask

	// most check words are codewords with zero, one or two flips, some with stray bits above; the rest noise
	task automatic queue_random_word(input dbits_t bits);
		word_t       w;
		int unsigned n;
		int unsigned pick;
		ecc_result_t enc;
		w = {$urandom, $urandom};
		n = code_width(bits);
		pick = $urandom_range(9);
		enc = predict_hamming(OP_ENCODE, w, bits);
		case (pick)
			0, 1, 2, 3: begin
				queue_word(OP_ENCODE, w);
			end
			4, 5: begin
				w = enc.code;
				w[$urandom_range(n - 1)] ^= 1'b1;
				queue_word(OP_CHECK, w);
			end
			6: begin
				queue_word(OP_CHECK, enc.code);
			end
			7: begin
				w = enc.code;
				w[$urandom_range(n - 1)] ^= 1'b1;
				w[$urandom_range(n - 1)] ^= 1'b1;
				queue_word(OP_CHECK, w);
			end
			8: begin
				queue_word(OP_CHECK, w);
			end
			default: begin
				w = enc.code | ({$urandom, $urandom} & ~code_mask(n));
				w[$urandom_range(n - 1)] ^= 1'b1;
				queue_word(OP_CHECK, w);
			end
		endcase
	endtask

	task automatic wait_drained();
		while (send_queue.size() != 0 || din_ch.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_data_bits(input dbits_t bits);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.data_bits <= bits;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin : driver
		ecc_word_t nxt;
		if (arst_n) begin
			dout_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (!din_ch.valid || word_taken) begin
				if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = send_queue.pop_front();
					din_ch.valid   <= 1'b1;
					din_ch.func    <= nxt.func;
					din_ch.word_in <= nxt.word;
				end else begin
					din_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		ecc_result_t want;
		if (arst_n) begin
			word_taken <= din_ch.valid && din_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				cfg_bits <= cfg_ch.data_bits;
			if (dout_ch.valid && dout_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", dout_ch.word_out, '0);
				end else begin
					want = expected_results.pop_front();
					if (dout_ch.word_out !== want.code)
						report_mismatch("word_out", dout_ch.word_out, want.code);
					if (dout_ch.error_position !== want.pos)
						report_mismatch("error_position", word_t'(dout_ch.error_position),
							word_t'(want.pos));
					if (dout_ch.corrected !== want.fixed)
						report_mismatch("corrected", word_t'(dout_ch.corrected),
							word_t'(want.fixed));
					if (dout_ch.bad_syndrome !== want.bad)
						report_mismatch("bad_syndrome", word_t'(dout_ch.bad_syndrome),
							word_t'(want.bad));
				end
			end
			if (din_ch.valid && din_ch.ready)
				expected_results.push_back(predict_hamming(din_ch.func, din_ch.word_in,
					cfg_bits));
		end
	end

	initial begin
		dbits_t seg_bits;
		din_ch.valid     = 1'b0;
		din_ch.func      = OP_ENCODE;
		din_ch.word_in   = '0;
		dout_ch.ready    = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data_bits = '0;
		send_idle_pct    = 8;
		recv_idle_pct    = 51;
		arst_n           = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// width after reset, stray bits above the data and the codeword
		queue_word(OP_ENCODE, '0);
		queue_word(OP_ENCODE, '1);
		queue_word(OP_CHECK, '0);
		queue_word(OP_CHECK, '1);
		queue_word(OP_CHECK, 64'h0000_0000_0000_0040);
		// zero width acts as one data bit
		write_data_bits(6'd0);
		queue_word(OP_ENCODE, 64'h1);
		queue_word(OP_CHECK, 64'h5);
		queue_word(OP_CHECK, '1);
		// syndromes past the codeword
		write_data_bits(6'd5);
		queue_word(OP_CHECK, 64'h082);
		queue_word(OP_CHECK, 64'h120);
		queue_word(OP_ENCODE, '1);
		// widest code, error in the last position
		write_data_bits(6'd57);
		queue_word(OP_ENCODE, '1);
		queue_word(OP_CHECK, '1);
		queue_word(OP_CHECK, 64'h4000_0000_0000_0000);
		// width above the top clamps
		write_data_bits(6'd63);
		queue_word(OP_ENCODE, 64'h8000_0000_0000_0000);
		queue_word(OP_CHECK, 64'h8000_0000_0000_0001);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == SEGMENTS / 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 8;
			end
			if (seg == 2 * SEGMENTS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			seg_bits = (seg < 10) ? WIDTH_PLAN[seg] : dbits_t'($urandom_range(63));
			write_data_bits(seg_bits);
			repeat (WORDS_PER_SEG) queue_random_word(seg_bits);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/hec_pkg.sv
design/hec_if.sv
design/hec_cfg.sv
design/hec_datapath.sv
design/hamming_encode_correct.sv
design/hec_checker.sv
dv/hamming_encode_correct_tb.sv
